>>> sv/shte_pkg.sv
package shte_pkg;

    localparam int QueueDepth = 4;
    localparam logic [3:0] RetryLimitReset = 4'd8;
    localparam logic [7:0] LineResetHighReset = 8'd64;
    localparam logic [15:0] SelectSeq = 16'hE79E;
    localparam logic [7:0] RequestBase = 8'h81;
    localparam logic [1:0] RdbuffReg = 2'd3;

    localparam logic [1:0] OpTick = 2'd0;
    localparam logic [1:0] OpStart = 2'd1;
    localparam logic [1:0] OpLineReset = 2'd2;

    localparam logic [2:0] AckOk = 3'd1;
    localparam logic [2:0] AckWait = 3'd2;

    localparam logic [1:0] StatusOk = 2'd0;
    localparam logic [1:0] StatusWait = 2'd1;
    localparam logic [1:0] StatusBadAck = 2'd2;
    localparam logic [1:0] StatusParity = 2'd3;

    localparam logic CfgRetryLimit = 1'b0;
    localparam logic CfgLineResetHigh = 1'b1;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_START,
        KIND_LINE_RESET
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic        ap_select;
        logic        read_request;
        logic [1:0]  reg_index;
        logic [31:0] write_data;
        logic        swdio_sample;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic        index;
        logic [7:0]  data;
    } cfg_write_t;

endpackage

>>> sv/shte_front.sv
module shte_front
    import shte_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    item_t          mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    item_t          push_item;
    logic           push, pop;

    // opcode three behaves as a tick
    always_comb begin
        push_item.ap_select    = s_tdata[0];
        push_item.read_request = s_tdata[1];
        push_item.reg_index    = s_tdata[3:2];
        push_item.write_data   = s_tdata[35:4];
        push_item.swdio_sample = s_tdata[36];
        unique case (s_tuser)
            OpStart:     push_item.kind = KIND_START;
            OpLineReset: push_item.kind = KIND_LINE_RESET;
            default:     push_item.kind = KIND_TICK;
        endcase
    end

    assign s_tready = (count_reg != FullCnt);
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/shte_back.sv
module shte_back
    import shte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_write_t  cfg_wr,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_REQ, PH_TURN_IN, PH_ACK, PH_RDATA, PH_RPAR, PH_TURN_RD,
        PH_TURN_WR, PH_WDATA, PH_WPAR, PH_FAULT_IDLE, PH_LR_HIGH1, PH_LR_SEQ,
        PH_LR_HIGH2, PH_LR_IDLE
    } phase_t;

    function automatic logic [7:0] request_byte(input logic ap, input logic rd,
                                                input logic [1:0] rg);
        logic p;
        p = ap ^ rd ^ rg[0] ^ rg[1];
        return RequestBase | {2'b00, p, rg[1], rg[0], rd, ap, 1'b0};
    endfunction

    phase_t      phase_reg, phase_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] held_reg, held_next;
    logic [3:0]  retry_reg, retry_next;
    logic        par_reg, par_next;
    logic        rdbuff_reg, rdbuff_next;
    logic        ap_reg, ap_next;
    logic        rd_reg, rd_next;
    logic [1:0]  rg_reg, rg_next;
    logic [2:0]  ack_reg, ack_next;
    logic        level_reg, level_next;
    logic        drive_reg, drive_next;
    logic [3:0]  retry_limit_reg;
    logic [7:0]  lr_high_reg;

    logic        m_tvalid_reg;
    logic        done_reg, done_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] rdata_reg, rdata_next;

    logic        step;
    logic        s;
    logic [7:0]  req;
    logic [8:0]  high_count;
    logic [2:0]  ack_tmp;

    assign q_ready = !m_tvalid_reg || m_tready;
    assign step    = q_valid && q_ready;
    assign s       = q_item.swdio_sample;
    assign req     = request_byte(ap_reg, rd_reg, rg_reg);
    assign high_count = (lr_high_reg == '0) ? 9'd1 : {1'b0, lr_high_reg};

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        held_next   = held_reg;
        retry_next  = retry_reg;
        par_next    = par_reg;
        rdbuff_next = rdbuff_reg;
        ap_next     = ap_reg;
        rd_next     = rd_reg;
        rg_next     = rg_reg;
        ack_next    = ack_reg;
        level_next  = level_reg;
        drive_next  = drive_reg;
        done_next   = 1'b0;
        status_next = StatusOk;
        rdata_next  = '0;
        ack_tmp     = ack_reg | (3'(s) << cnt_reg[1:0]);

        if (phase_reg == PH_IDLE && q_item.kind == KIND_START) begin
            ap_next     = q_item.ap_select;
            rd_next     = q_item.read_request;
            rg_next     = q_item.reg_index;
            held_next   = q_item.write_data;
            shift_next  = '0;
            par_next    = 1'b0;
            rdbuff_next = 1'b0;
            retry_next  = '0;
            phase_next  = PH_REQ;
            cnt_next    = '0;
            drive_next  = 1'b1;
            level_next  = 1'b1;
        end else if (phase_reg == PH_IDLE && q_item.kind == KIND_LINE_RESET) begin
            phase_next = PH_LR_HIGH1;
            cnt_next   = '0;
            drive_next = 1'b1;
            level_next = 1'b1;
        end else if (phase_reg != PH_IDLE) begin
            unique case (phase_reg)
                PH_REQ: begin
                    if (cnt_reg < 8'd7) begin
                        cnt_next   = cnt_reg + 8'd1;
                        drive_next = 1'b1;
                        level_next = req[cnt_reg[2:0] + 3'd1];
                    end else begin
                        ack_next   = '0;
                        phase_next = PH_TURN_IN;
                        cnt_next   = '0;
                        drive_next = 1'b0;
                    end
                end
                PH_TURN_IN: begin
                    phase_next = PH_ACK;
                    cnt_next   = '0;
                    drive_next = 1'b0;
                end
                PH_ACK: begin
                    ack_next = ack_tmp;
                    cnt_next = '0;
                    if (cnt_reg < 8'd2) begin
                        cnt_next   = cnt_reg + 8'd1;
                        drive_next = 1'b0;
                    end else if (ack_tmp == AckOk) begin
                        drive_next = 1'b0;
                        if (rd_reg) begin
                            shift_next = '0;
                            par_next   = 1'b0;
                            phase_next = PH_RDATA;
                        end else begin
                            phase_next = PH_TURN_WR;
                            level_next = held_reg[0];
                        end
                    end else begin
                        phase_next = PH_FAULT_IDLE;
                        drive_next = 1'b1;
                        level_next = 1'b0;
                    end
                end
                PH_RDATA: begin
                    shift_next[cnt_reg[4:0]] = shift_reg[cnt_reg[4:0]] | s;
                    par_next   = par_reg ^ s;
                    drive_next = 1'b0;
                    if (cnt_reg < 8'd31) begin
                        cnt_next = cnt_reg + 8'd1;
                    end else begin
                        phase_next = PH_RPAR;
                        cnt_next   = '0;
                    end
                end
                PH_RPAR: begin
                    par_next   = par_reg ^ s;
                    phase_next = PH_TURN_RD;
                    cnt_next   = '0;
                    drive_next = 1'b0;
                end
                PH_TURN_RD: begin
                    drive_next = 1'b1;
                    level_next = 1'b1;
                    cnt_next   = '0;
                    if (par_reg) begin
                        phase_next  = PH_IDLE;
                        done_next   = 1'b1;
                        status_next = StatusParity;
                    end else if (ap_reg && !rdbuff_reg) begin
                        ap_next     = 1'b0;
                        rd_next     = 1'b1;
                        rg_next     = RdbuffReg;
                        rdbuff_next = 1'b1;
                        retry_next  = '0;
                        phase_next  = PH_REQ;
                    end else begin
                        phase_next  = PH_IDLE;
                        done_next   = 1'b1;
                        status_next = StatusOk;
                        rdata_next  = rd_reg ? shift_reg : '0;
                    end
                end
                PH_TURN_WR: begin
                    phase_next = PH_WDATA;
                    cnt_next   = '0;
                    drive_next = 1'b1;
                    level_next = held_reg[0];
                end
                PH_WDATA: begin
                    drive_next = 1'b1;
                    if (cnt_reg < 8'd31) begin
                        cnt_next   = cnt_reg + 8'd1;
                        level_next = held_reg[cnt_reg[4:0] + 5'd1];
                    end else begin
                        phase_next = PH_WPAR;
                        cnt_next   = '0;
                        level_next = ^held_reg;
                    end
                end
                PH_WPAR: begin
                    phase_next  = PH_IDLE;
                    cnt_next    = '0;
                    done_next   = 1'b1;
                    status_next = StatusOk;
                    rdata_next  = rd_reg ? shift_reg : '0;
                end
                PH_FAULT_IDLE: begin
                    if (cnt_reg < 8'd7) begin
                        cnt_next   = cnt_reg + 8'd1;
                        drive_next = 1'b1;
                        level_next = 1'b0;
                    end else if (ack_reg == AckWait && !ap_reg &&
                                 ({1'b0, retry_reg} + 5'd1) < {1'b0, retry_limit_reg}) begin
                        retry_next = retry_reg + 4'd1;
                        phase_next = PH_REQ;
                        cnt_next   = '0;
                        drive_next = 1'b1;
                        level_next = 1'b1;
                    end else begin
                        phase_next  = PH_IDLE;
                        cnt_next    = '0;
                        done_next   = 1'b1;
                        status_next = (ack_reg == AckWait) ? StatusWait : StatusBadAck;
                    end
                end
                PH_LR_HIGH1, PH_LR_HIGH2: begin
                    drive_next = 1'b1;
                    if (({1'b0, cnt_reg} + 9'd1) < high_count) begin
                        cnt_next   = cnt_reg + 8'd1;
                        level_next = 1'b1;
                    end else begin
                        cnt_next = '0;
                        if (phase_reg == PH_LR_HIGH1) begin
                            phase_next = PH_LR_SEQ;
                            level_next = SelectSeq[0];
                        end else begin
                            phase_next = PH_LR_IDLE;
                            level_next = 1'b0;
                        end
                    end
                end
                PH_LR_SEQ: begin
                    drive_next = 1'b1;
                    if (cnt_reg < 8'd15) begin
                        cnt_next   = cnt_reg + 8'd1;
                        level_next = SelectSeq[cnt_reg[3:0] + 4'd1];
                    end else begin
                        phase_next = PH_LR_HIGH2;
                        cnt_next   = '0;
                        level_next = 1'b1;
                    end
                end
                PH_LR_IDLE: begin
                    drive_next = 1'b1;
                    level_next = 1'b0;
                    if (cnt_reg < 8'd7) begin
                        cnt_next = cnt_reg + 8'd1;
                    end else begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            cnt_reg         <= '0;
            shift_reg       <= '0;
            held_reg        <= '0;
            retry_reg       <= '0;
            par_reg         <= 1'b0;
            rdbuff_reg      <= 1'b0;
            ap_reg          <= 1'b0;
            rd_reg          <= 1'b0;
            rg_reg          <= '0;
            ack_reg         <= '0;
            level_reg       <= 1'b1;
            drive_reg       <= 1'b1;
            retry_limit_reg <= RetryLimitReset;
            lr_high_reg     <= LineResetHighReset;
            m_tvalid_reg    <= 1'b0;
            done_reg        <= 1'b0;
            status_reg      <= StatusOk;
            rdata_reg       <= '0;
        end else begin
            if (cfg_wr.valid && cfg_wr.index == CfgRetryLimit) begin
                retry_limit_reg <= cfg_wr.data[3:0];
            end
            if (cfg_wr.valid && cfg_wr.index == CfgLineResetHigh) begin
                lr_high_reg <= cfg_wr.data;
            end
            if (q_ready) begin
                m_tvalid_reg <= q_valid;
            end
            if (step) begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                shift_reg  <= shift_next;
                held_reg   <= held_next;
                retry_reg  <= retry_next;
                par_reg    <= par_next;
                rdbuff_reg <= rdbuff_next;
                ap_reg     <= ap_next;
                rd_reg     <= rd_next;
                rg_reg     <= rg_next;
                ack_reg    <= ack_next;
                level_reg  <= level_next;
                drive_reg  <= drive_next;
                done_reg   <= done_next;
                status_reg <= status_next;
                rdata_reg  <= rdata_next;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, status_reg, rdata_reg, ack_reg, done_reg,
                       phase_reg != PH_IDLE, phase_reg != PH_IDLE, drive_reg, level_reg};

`ifndef ASSERT_OFF
    a_released_in_target_phases: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ACK || phase_reg == PH_RDATA || phase_reg == PH_RPAR)
        |-> !drive_reg)
        else $error("host drives swdio while target owns the line");

    a_done_only_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && done_reg) |-> (phase_reg == PH_IDLE))
        else $error("access reported done while still busy");

    a_rdbuff_is_dp: assert property (@(posedge aclk) disable iff (!aresetn)
        rdbuff_reg |-> (!ap_reg && rd_reg && rg_reg == RdbuffReg))
        else $error("rdbuff read not a dp read of rdbuff");

    a_state_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(phase_reg) && $stable(cnt_reg))
        else $error("engine advanced while result word was stalled");
`endif

endmodule

>>> sv/swd_host_transfer_engine.sv
// SWD host transfer engine: each input word is one SWD bit cycle (tuser opcode 0 tick with
// the sampled SWDIO bit, 1 start access, 2 line reset and select SWD) and each yields exactly
// one result word telling what to drive and whether to clock SWCLK next cycle; an access
// acknowledged OK runs request, turnaround, ack, data and parity words, a non-OK ack runs
// idle words in place of the data phase, each WAIT retry of a DP access repeats the attempt
// and an AP read adds an RDBUFF read; a line reset holds the line high for the high count,
// sends the select sequence, holds it high again, then idle words. Words pass the input queue
// and the result register; one word is accepted and one result produced per clock while the
// output is not stalled, limited by the single-cycle sequencer step. Configuration writes (index 0
// WAIT retry limit, index 1 line-reset high count) must go in while idle; the block does not enforce it.
module swd_host_transfer_engine
    import shte_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // ap_select, read_request, reg_index[1:0], write_data[31:0],
                                   // swdio_sample, zero pad
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // swdio_out, swdio_drive, clock_pulse, busy_res, done_res,
                                   // ack_code[2:0], read_data[31:0], status[1:0], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic       q_valid;
    logic       q_ready;
    item_t      q_item;
    cfg_write_t cfg_wr;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    shte_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    shte_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> dv/tb.sv
module tb;
    import shte_pkg::*;

    localparam logic [1:0] OpSpare = 2'd3;
    localparam logic [2:0] AckFault = 3'd4;
    localparam int TotalWords = 1450;
    localparam int QuietLimit = 4000;
    localparam int MaxReports = 200;

    typedef enum logic [3:0] {
        P_IDLE, P_REQ, P_TURN_IN, P_ACK, P_RDATA, P_RPAR, P_TURN_RD, P_TURN_WR,
        P_WDATA, P_WPAR, P_FAULT_IDLE, P_LR_HIGH1, P_LR_SEQ, P_LR_HIGH2, P_LR_IDLE
    } phase_e;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rdata;
        logic [2:0]  ack;
        logic        done;
        logic        busy;
        logic        clk;
        logic        drv;
        logic        out;
    } swd_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = OpTick;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CfgRetryLimit;
    logic [7:0]  cfg_data = '0;

    swd_host_transfer_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // engine state as predicted
    phase_e      ph = P_IDLE;
    logic [7:0]  bcnt = '0;
    logic [31:0] shw = '0;
    logic [31:0] hww = '0;
    logic [3:0]  rtry = '0;
    logic        pacc = 1'b0;
    logic        rdb_pend = 1'b0;
    logic        l_ap = 1'b0;
    logic        l_rd = 1'b0;
    logic [1:0]  l_reg = '0;
    logic [2:0]  ack_reg = '0;
    logic        lvl = 1'b1;
    logic        drv = 1'b1;
    logic [3:0]  retry_lim = RetryLimitReset;
    logic [7:0]  lr_high = LineResetHighReset;
    logic        fin_done;
    logic [1:0]  fin_status;
    logic [31:0] fin_data;

    // target side of the wire
    logic [2:0]  ack_plan [$];
    logic [31:0] word_plan [$];
    logic        perr_plan [$];
    logic [2:0]  cur_ack = AckOk;
    logic [31:0] cur_word = '0;
    logic        cur_perr = 1'b0;

    swd_result_t expected_steps [$];
    int idle_pct = 24;
    int noise_pct = 3;
    int errors = 0;
    int n_words = 0;
    int n_checked = 0;
    int n_accesses = 0;
    int n_line_resets = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int quiet_cycles = 0;

    function automatic void go(phase_e nph, int cnt, logic d, logic l);
        ph = nph;
        bcnt = cnt[7:0];
        drv = d;
        lvl = l;
    endfunction

    function automatic logic [7:0] req_byte();
        logic p;
        p = l_ap ^ l_rd ^ l_reg[0] ^ l_reg[1];
        return RequestBase | {2'b00, p, l_reg[1], l_reg[0], l_rd, l_ap, 1'b0};
    endfunction

    function automatic void begin_req();
        logic [7:0] rb;
        rb = req_byte();
        go(P_REQ, 0, 1'b1, rb[0]);
    endfunction

    function automatic void finish_access(logic [1:0] st);
        ph = P_IDLE;
        bcnt = '0;
        fin_done = 1'b1;
        fin_status = st;
        fin_data = (st == StatusOk && l_rd) ? shw : '0;
    endfunction

    function automatic int high_cnt();
        return (lr_high == 8'd0) ? 1 : int'(lr_high);
    endfunction

    function automatic void advance(logic s);
        int c;
        logic [7:0] rb;
        c = int'(bcnt);
        rb = req_byte();
        case (ph)
            P_REQ: begin
                if (c < 7) begin
                    go(P_REQ, c + 1, 1'b1, rb[c + 1]);
                end else begin
                    ack_reg = '0;
                    go(P_TURN_IN, 0, 1'b0, lvl);
                end
            end
            P_TURN_IN: go(P_ACK, 0, 1'b0, lvl);
            P_ACK: begin
                ack_reg[c] = ack_reg[c] | s;
                if (c < 2) begin
                    go(P_ACK, c + 1, 1'b0, lvl);
                end else if (ack_reg == AckOk) begin
                    if (l_rd) begin
                        shw = '0;
                        pacc = 1'b0;
                        go(P_RDATA, 0, 1'b0, lvl);
                    end else begin
                        go(P_TURN_WR, 0, 1'b0, hww[0]);
                    end
                end else begin
                    go(P_FAULT_IDLE, 0, 1'b1, 1'b0);
                end
            end
            P_RDATA: begin
                shw[c] = shw[c] | s;
                pacc = pacc ^ s;
                if (c < 31) go(P_RDATA, c + 1, 1'b0, lvl);
                else go(P_RPAR, 0, 1'b0, lvl);
            end
            P_RPAR: begin
                pacc = pacc ^ s;
                go(P_TURN_RD, 0, 1'b0, lvl);
            end
            P_TURN_RD: begin
                drv = 1'b1;
                lvl = 1'b1;
                if (pacc) begin
                    finish_access(StatusParity);
                end else if (l_ap && !rdb_pend) begin
                    l_ap = 1'b0;
                    l_rd = 1'b1;
                    l_reg = RdbuffReg;
                    rdb_pend = 1'b1;
                    rtry = '0;
                    begin_req();
                end else begin
                    finish_access(StatusOk);
                end
            end
            P_TURN_WR: go(P_WDATA, 0, 1'b1, hww[0]);
            P_WDATA: begin
                if (c < 31) go(P_WDATA, c + 1, 1'b1, hww[c + 1]);
                else go(P_WPAR, 0, 1'b1, ^hww);
            end
            P_WPAR: finish_access(StatusOk);
            P_FAULT_IDLE: begin
                if (c < 7) begin
                    go(P_FAULT_IDLE, c + 1, 1'b1, 1'b0);
                end else if (ack_reg == AckWait && !l_ap && int'(rtry) + 1 < int'(retry_lim)) begin
                    rtry = rtry + 4'd1;
                    begin_req();
                end else begin
                    finish_access(ack_reg == AckWait ? StatusWait : StatusBadAck);
                end
            end
            P_LR_HIGH1: begin
                if (c + 1 < high_cnt()) go(P_LR_HIGH1, c + 1, 1'b1, 1'b1);
                else go(P_LR_SEQ, 0, 1'b1, SelectSeq[0]);
            end
            P_LR_SEQ: begin
                if (c < 15) go(P_LR_SEQ, c + 1, 1'b1, SelectSeq[c + 1]);
                else go(P_LR_HIGH2, 0, 1'b1, 1'b1);
            end
            P_LR_HIGH2: begin
                if (c + 1 < high_cnt()) go(P_LR_HIGH2, c + 1, 1'b1, 1'b1);
                else go(P_LR_IDLE, 0, 1'b1, 1'b0);
            end
            P_LR_IDLE: begin
                if (c < 7) go(P_LR_IDLE, c + 1, 1'b1, 1'b0);
                else go(P_IDLE, 0, 1'b1, 1'b0);
            end
            default: begin
                ph = P_IDLE;
                bcnt = '0;
            end
        endcase
    endfunction

    function automatic swd_result_t step_engine(logic [1:0] op, logic ap, logic rd,
                                                logic [1:0] rsel, logic [31:0] wdata,
                                                logic s);
        swd_result_t r;
        fin_done = 1'b0;
        fin_status = StatusOk;
        fin_data = '0;
        if (ph == P_IDLE && op == OpStart) begin
            l_ap = ap;
            l_rd = rd;
            l_reg = rsel;
            hww = wdata;
            shw = '0;
            pacc = 1'b0;
            rdb_pend = 1'b0;
            rtry = '0;
            begin_req();
        end else if (ph == P_IDLE && op == OpLineReset) begin
            go(P_LR_HIGH1, 0, 1'b1, 1'b1);
        end else if (ph != P_IDLE) begin
            advance(s);
        end
        r.out = lvl;
        r.drv = drv;
        r.clk = (ph != P_IDLE);
        r.busy = (ph != P_IDLE);
        r.done = fin_done;
        r.ack = ack_reg;
        r.rdata = fin_data;
        r.status = fin_status;
        return r;
    endfunction

    function automatic logic [2:0] random_ack();
        int r;
        r = $urandom_range(99);
        if (r < 72) return AckOk;
        if (r < 86) return AckWait;
        if (r < 93) return AckFault;
        return 3'($urandom_range(7));
    endfunction

    // level the target puts on the wire for the bit cycle the engine is in
    function automatic logic target_bit();
        case (ph)
            P_ACK: begin
                if (bcnt == 8'd0) cur_ack = (ack_plan.size() != 0) ? ack_plan.pop_front()
                                                                   : random_ack();
                return cur_ack[bcnt[1:0]];
            end
            P_RDATA: begin
                if (bcnt == 8'd0) begin
                    cur_word = (word_plan.size() != 0) ? word_plan.pop_front() : $urandom();
                    cur_perr = (perr_plan.size() != 0) ? perr_plan.pop_front()
                                                       : ($urandom_range(99) < 4);
                end
                return cur_word[bcnt[4:0]];
            end
            P_RPAR: return (^cur_word) ^ cur_perr;
            default: return 1'($urandom_range(1));
        endcase
    endfunction

    task automatic send_word(logic [1:0] op, logic ap, logic rd, logic [1:0] rsel,
                             logic [31:0] wdata, logic s);
        swd_result_t r;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, s, wdata, rsel, rd, ap};
        do @(posedge aclk); while (!s_tready);
        r = step_engine(op, ap, rd, rsel, wdata, s);
        expected_steps.push_back(r);
        n_words++;
        if (r.done) status_seen[r.status]++;
        @(negedge aclk);
    endtask

    task automatic tick_once();
        logic s;
        logic [1:0] op;
        s = target_bit();
        op = OpTick;
        if (ph != P_IDLE && $urandom_range(99) < noise_pct) op = 2'($urandom_range(1, 3));
        else if ($urandom_range(99) < 5) op = OpSpare;
        send_word(op, 1'($urandom_range(1)), 1'($urandom_range(1)), 2'($urandom_range(3)),
                  $urandom(), s);
    endtask

    task automatic access(logic ap, logic rd, logic [1:0] rsel, logic [31:0] wdata);
        send_word(OpStart, ap, rd, rsel, wdata, 1'($urandom_range(1)));
        n_accesses++;
        while (ph != P_IDLE) tick_once();
        ack_plan.delete();
        word_plan.delete();
        perr_plan.delete();
    endtask

    task automatic line_reset();
        send_word(OpLineReset, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  2'($urandom_range(3)), $urandom(), 1'($urandom_range(1)));
        n_line_resets++;
        while (ph != P_IDLE) tick_once();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(logic idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CfgRetryLimit) retry_lim = val[3:0];
        else lr_high = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_idle_ticks();
        send_word(OpTick, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1);
        send_word(OpSpare, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0);
        send_word(OpTick, 1'b0, 1'b1, 2'd1, $urandom(), 1'b1);
    endtask

    task automatic test_dp_accesses();
        ack_plan.push_back(AckOk);
        access(1'b0, 1'b0, 2'd0, 32'hFFFF_FFFF);
        ack_plan.push_back(AckOk);
        word_plan.push_back(32'h0);
        perr_plan.push_back(1'b0);
        access(1'b0, 1'b1, 2'd3, $urandom());
        ack_plan.push_back(AckOk);
        word_plan.push_back(32'hFFFF_FFFF);
        perr_plan.push_back(1'b0);
        access(1'b0, 1'b1, 2'd1, $urandom());
    endtask

    task automatic test_ap_accesses();
        ack_plan.push_back(AckOk);
        ack_plan.push_back(AckOk);
        word_plan.push_back(32'hA5A5_5A5A);
        word_plan.push_back($urandom());
        perr_plan.push_back(1'b0);
        perr_plan.push_back(1'b0);
        access(1'b1, 1'b1, 2'd0, $urandom());
        ack_plan.push_back(AckOk);
        access(1'b1, 1'b0, 2'd3, $urandom());
    endtask

    task automatic test_bad_acks();
        ack_plan = '{AckWait, AckWait, AckOk};
        access(1'b0, 1'b1, 2'd2, $urandom());
        repeat (8) ack_plan.push_back(AckWait);
        access(1'b0, 1'b0, 2'd1, $urandom());
        ack_plan.push_back(AckWait);
        access(1'b1, 1'b0, 2'd1, $urandom());
        ack_plan.push_back(AckFault);
        access(1'b0, 1'b1, 2'd0, $urandom());
        ack_plan.push_back(3'd0);
        access(1'b1, 1'b1, 2'd2, $urandom());
        ack_plan.push_back(3'd7);
        access(1'b0, 1'b0, 2'd3, $urandom());
        // rdbuff stage is a dp access, so it retries
        ack_plan = '{AckOk, AckWait, AckOk};
        access(1'b1, 1'b1, 2'd1, $urandom());
    endtask

    task automatic test_parity_errors();
        ack_plan.push_back(AckOk);
        perr_plan.push_back(1'b1);
        access(1'b0, 1'b1, 2'd0, $urandom());
        ack_plan.push_back(AckOk);
        perr_plan.push_back(1'b1);
        access(1'b1, 1'b1, 2'd3, $urandom());
        ack_plan = '{AckOk, AckOk};
        perr_plan = '{1'b0, 1'b1};
        access(1'b1, 1'b1, 2'd2, $urandom());
    endtask

    task automatic test_busy_requests();
        noise_pct = 40;
        access(1'b1, 1'b1, 2'($urandom_range(3)), $urandom());
        drain();
        line_reset();
        noise_pct = 3;
    endtask

    task automatic test_retry_limits();
        int lims [3] = '{0, 1, 3};
        foreach (lims[i]) begin
            drain();
            cfg_write(CfgRetryLimit, {4'($urandom_range(15)), 4'(lims[i])});
            repeat (16) ack_plan.push_back(AckWait);
            access(1'b0, 1'($urandom_range(1)), 2'($urandom_range(3)), $urandom());
        end
    endtask

    task automatic test_line_reset();
        int highs [2] = '{0, 1};
        foreach (highs[i]) begin
            drain();
            cfg_write(CfgLineResetHigh, 8'(highs[i]));
            line_reset();
        end
    endtask

    task automatic test_random();
        int round;
        int r;
        round = 0;
        while (round == 0 || n_words < TotalWords) begin
            drain();
            cfg_write(CfgRetryLimit, 8'($urandom_range(255)));
            cfg_write(CfgLineResetHigh, ($urandom_range(99) < 75) ? 8'($urandom_range(6))
                                                                 : 8'($urandom_range(50, 70)));
            idle_pct = (round == 0) ? 0 : 24;
            repeat ($urandom_range(4, 10)) begin
                r = $urandom_range(99);
                if (r < 84) begin
                    access(1'($urandom_range(1)), 1'($urandom_range(1)),
                           2'($urandom_range(3)), $urandom());
                end else if (r < 92) begin
                    line_reset();
                end else begin
                    repeat ($urandom_range(1, 3))
                        send_word($urandom_range(1) ? OpTick : OpSpare, 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 2'($urandom_range(3)), $urandom(),
                                  1'($urandom_range(1)));
                end
            end
            round++;
        end
        idle_pct = 24;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MaxReports)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        swd_result_t got;
        swd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = swd_result_t'(m_tdata[41:0]);
            if (expected_steps.size() == 0) begin
                errors++;
                $display("%0t: result word %h with nothing expected", $time, m_tdata);
            end else begin
                want = expected_steps.pop_front();
                cmp_field("swdio_out", want.out, got.out);
                cmp_field("swdio_drive", want.drv, got.drv);
                cmp_field("clock_pulse", want.clk, got.clk);
                cmp_field("busy_res", want.busy, got.busy);
                cmp_field("done_res", want.done, got.done);
                cmp_field("ack_code", want.ack, got.ack);
                cmp_field("read_data", want.rdata, got.rdata);
                cmp_field("status", want.status, got.status);
                n_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no progress, %0d results outstanding", $time, expected_steps.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_idle_ticks();
        test_dp_accesses();
        test_ap_accesses();
        test_bad_acks();
        test_parity_errors();
        test_busy_requests();
        test_retry_limits();
        test_line_reset();
        test_random();
        drain();
        $display("covered %0d words, %0d results checked, %0d accesses, %0d line resets",
                 n_words, n_checked, n_accesses, n_line_resets);
        $display("accesses ending ok %0d, wait %0d, bad ack %0d, parity %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && expected_steps.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/shte_pkg.sv
sv/shte_front.sv
sv/shte_back.sv
sv/swd_host_transfer_engine.sv
dv/tb.sv
